// ----- rtl/csv_field_tokenizer_core_defines.svh -----
// assertion macros shared by the csv field tokenizer rtl
// depends on nothing; included by csvt_parse and csvt_out_buf
`ifndef CSV_FIELD_TOKENIZER_CORE_DEFINES_SVH
`define CSV_FIELD_TOKENIZER_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define CSVT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csvt assertion failed");

// next-cycle implication, held off during reset
`define CSVT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csvt assertion failed");

`endif

// ----- rtl/csvt_pkg.sv -----
// shared types and constants for the csv field tokenizer
// no dependencies; used by csvt_parse, csvt_out_buf and the top level
`default_nettype none

package csvt_pkg;

    // row and column limits
    localparam int MAX_COLUMNS = 64;
    localparam int MAX_LINE    = 1024;

    // field widths
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int LEN_W  = $clog2(MAX_LINE);

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int PTR_W  = $clog2(QDEPTH);
    localparam int CNT_W  = $clog2(QDEPTH + 1);

    // special bytes
    localparam logic [CHAR_W-1:0] CHAR_DQUOTE  = 8'h22;
    localparam logic [CHAR_W-1:0] CHAR_SQUOTE  = 8'h27;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;

    // separator reset value
    localparam logic [CHAR_W-1:0] SEPARATOR_RESET = 8'h2C;

    // request opcodes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    typedef enum logic [1:0] {
        KIND_CONTENT = 2'd0,
        KIND_BREAK   = 2'd1,
        KIND_ROW_END = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t               kind;
        logic [COL_W-1:0]    column_index;
        logic [CHAR_W-1:0]   out_char;
        logic [COL_W-1:0]    final_index;
        logic                last;
    } result_t;

    // up to two results produced by one request
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } push_t;

    // row end result for a given column, capped at the column limit
    function automatic result_t row_end_result(input logic [COL_W-1:0] col);
        logic [COL_W-1:0] fin;
        result_t          r;
        fin = (col > COL_W'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS) : col;
        r.kind         = KIND_ROW_END;
        r.column_index = fin;
        r.out_char     = '0;
        r.final_index  = fin;
        r.last         = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/csvt_parse.sv -----
// per-byte tokenizer state machine: quote, column, row length and skip tracking
// depends on csvt_pkg and csv_field_tokenizer_core_defines.svh
`default_nettype none

`include "csv_field_tokenizer_core_defines.svh"

module csvt_parse (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire logic                         op,
    input  wire logic [csvt_pkg::CHAR_W-1:0]  in_byte,
    input  wire logic [csvt_pkg::CHAR_W-1:0]  separator,
    output csvt_pkg::push_t                   push
);

    logic                        quoted_reg, quoted_next;
    logic                        qsingle_reg, qsingle_next;
    logic [csvt_pkg::COL_W-1:0]  col_reg, col_next;
    logic [csvt_pkg::LEN_W-1:0]  len_reg, len_next;
    logic                        skip_reg, skip_next;

    csvt_pkg::result_t           data_res;
    logic                        data_vld;
    logic                        row_end;
    logic [csvt_pkg::LEN_W-1:0]  len_inc;
    logic [csvt_pkg::COL_W-1:0]  col_inc;
    logic [csvt_pkg::CHAR_W-1:0] close_quote;

    assign len_inc     = len_reg + 1'b1;
    assign col_inc     = col_reg + 1'b1;
    assign close_quote = qsingle_reg ? csvt_pkg::CHAR_SQUOTE : csvt_pkg::CHAR_DQUOTE;

    // next state and results for one request
    always_comb
    begin
        quoted_next  = quoted_reg;
        qsingle_next = qsingle_reg;
        col_next     = col_reg;
        len_next     = len_reg;
        skip_next    = skip_reg;
        data_vld     = 1'b0;
        row_end      = 1'b0;

        data_res.kind         = csvt_pkg::KIND_CONTENT;
        data_res.column_index = col_reg;
        data_res.out_char     = in_byte;
        data_res.final_index  = '0;
        data_res.last         = 1'b0;

        if (op == csvt_pkg::OP_EOF)
        begin
            row_end = (len_reg != '0);
        end
        else if (in_byte == csvt_pkg::CHAR_NEWLINE)
        begin
            row_end = 1'b1;
        end
        else
        begin
            if (!skip_reg)
            begin
                priority if (in_byte == csvt_pkg::CHAR_NUL)
                begin
                    skip_next = 1'b1;
                end
                else if (quoted_reg)
                begin
                    if (in_byte == close_quote)
                        quoted_next = 1'b0;
                    else
                        data_vld = 1'b1;
                end
                else if (in_byte == csvt_pkg::CHAR_DQUOTE ||
                         in_byte == csvt_pkg::CHAR_SQUOTE)
                begin
                    quoted_next  = 1'b1;
                    qsingle_next = (in_byte == csvt_pkg::CHAR_SQUOTE);
                end
                else if (in_byte == separator)
                begin
                    col_next              = col_inc;
                    data_vld              = 1'b1;
                    data_res.kind         = csvt_pkg::KIND_BREAK;
                    data_res.column_index = col_inc;
                    data_res.out_char     = '0;
                    if (col_inc >= csvt_pkg::COL_W'(csvt_pkg::MAX_COLUMNS))
                        skip_next = 1'b1;
                end
                else
                begin
                    data_vld = 1'b1;
                end
            end
            len_next = len_inc;
            row_end  = (len_inc >= csvt_pkg::LEN_W'(csvt_pkg::MAX_LINE - 1));
        end

        // row end clears the row state
        if (row_end)
        begin
            quoted_next  = 1'b0;
            qsingle_next = 1'b0;
            skip_next    = 1'b0;
            col_next     = '0;
            len_next     = '0;
        end

        // pack results, row end always last
        data_res.last = !row_end;
        push.res1     = csvt_pkg::row_end_result(col_next == '0 ? col_inc : col_next);
        if (data_vld)
        begin
            push.res0  = data_res;
            push.res1  = csvt_pkg::row_end_result(data_res.kind == csvt_pkg::KIND_BREAK ?
                                                  col_inc : col_reg);
            push.count = row_end ? 2'd2 : 2'd1;
        end
        else
        begin
            push.res0  = csvt_pkg::row_end_result(col_reg);
            push.count = row_end ? 2'd1 : 2'd0;
        end
        if (!accept)
            push.count = 2'd0;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quoted_reg  <= 1'b0;
            qsingle_reg <= 1'b0;
            col_reg     <= '0;
            len_reg     <= '0;
            skip_reg    <= 1'b0;
        end
        else if (accept)
        begin
            quoted_reg  <= quoted_next;
            qsingle_reg <= qsingle_next;
            col_reg     <= col_next;
            len_reg     <= len_next;
            skip_reg    <= skip_next;
        end
    end

    // row length never reaches the line limit between requests
    `CSVT_ASSERT_NOW(a_len_bound, clk, rst_n, 1'b1,
        len_reg < csvt_pkg::LEN_W'(csvt_pkg::MAX_LINE - 1))
    // column never passes the column limit
    `CSVT_ASSERT_NOW(a_col_bound, clk, rst_n, 1'b1,
        col_reg <= csvt_pkg::COL_W'(csvt_pkg::MAX_COLUMNS))
    // a row end pushed clears the row state
    `CSVT_ASSERT_NEXT(a_row_clear, clk, rst_n,
        accept && push.count != 2'd0 &&
        ((push.count == 2'd1 && push.res0.kind == csvt_pkg::KIND_ROW_END) ||
         push.count == 2'd2),
        col_reg == '0 && len_reg == '0 && !quoted_reg && !skip_reg)

endmodule

`default_nettype wire

// ----- rtl/csvt_out_buf.sv -----
// four-entry result queue: up to two in per cycle, one out per cycle on out_ready
// depends on csvt_pkg and csv_field_tokenizer_core_defines.svh
`default_nettype none

`include "csv_field_tokenizer_core_defines.svh"

module csvt_out_buf (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire csvt_pkg::push_t    push,
    output logic                    space,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output csvt_pkg::result_t       out_res
);

    csvt_pkg::result_t                q_reg [csvt_pkg::QDEPTH];
    logic [csvt_pkg::PTR_W-1:0]       head_reg, head_next;
    logic [csvt_pkg::PTR_W-1:0]       tail_reg, tail_next;
    logic [csvt_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [csvt_pkg::PTR_W-1:0]       tail_plus1;
    logic                             pop;

    // room for two more results
    assign space      = (count_reg <= csvt_pkg::CNT_W'(csvt_pkg::QDEPTH - 2));
    assign out_valid  = (count_reg != '0);
    assign out_res    = q_reg[head_reg];
    assign pop        = out_valid && out_ready;
    assign tail_plus1 = tail_reg + 1'b1;

    // pointer and fill update
    always_comb
    begin
        head_next  = head_reg + csvt_pkg::PTR_W'(pop);
        tail_next  = tail_reg + csvt_pkg::PTR_W'(push.count);
        count_next = count_reg + csvt_pkg::CNT_W'(push.count) - csvt_pkg::CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            q_reg[tail_reg] <= push.res0;
        if (push.count == 2'd2)
            q_reg[tail_plus1] <= push.res1;
    end

    // fill never exceeds the depth
    `CSVT_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1,
        count_reg <= csvt_pkg::CNT_W'(csvt_pkg::QDEPTH))
    // results only arrive when room was advertised
    `CSVT_ASSERT_NOW(a_push_room, clk, rst_n, push.count != 2'd0, space)
    // pointers stay consistent with the fill count
    `CSVT_ASSERT_NOW(a_ptr_fill, clk, rst_n, count_reg != csvt_pkg::CNT_W'(csvt_pkg::QDEPTH),
        csvt_pkg::PTR_W'(tail_reg - head_reg) == csvt_pkg::PTR_W'(count_reg))

endmodule

`default_nettype wire

// ----- rtl/csv_field_tokenizer_core.sv -----
// top level of the csv field tokenizer: separator register, tokenizer, result queue
// depends on csvt_pkg, csvt_parse and csvt_out_buf
`default_nettype none

// Splits a byte stream into rows and columns, one request (a byte or an end of
// file) per clock. Each request is decoded in the same cycle it is accepted and its
// results (none, one, or two when a byte also hits the line length limit) go into a
// four-entry result queue; in_ready stays high while the queue holds two results or
// fewer, so with a consumer that takes a result every cycle the block sustains one
// request per cycle. A request yielding two results sends them in turn to the
// single output port. Quote characters are dropped, a separator inside quotes is
// data, a row end reports the capped final column. The user must write the
// separator through cfg_write_en/cfg_write_data only while idle (not enforced).
module csv_field_tokenizer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_en,
    input  wire logic [7:0]  cfg_write_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [6:0]       column_index,
    output logic [7:0]       out_char,
    output logic [6:0]       final_index,
    output logic             last
);

    logic [csvt_pkg::CHAR_W-1:0] separator_reg;
    logic                        accept;
    csvt_pkg::push_t             push;
    csvt_pkg::result_t           res;

    assign accept = in_valid && in_ready;

    // separator register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            separator_reg <= csvt_pkg::SEPARATOR_RESET;
        else if (cfg_write_en)
            separator_reg <= cfg_write_data;
    end

    // tokenizer state and decode
    csvt_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .op        (op),
        .in_byte   (in_byte),
        .separator (separator_reg),
        .push      (push)
    );

    // result queue
    csvt_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (res)
    );

    // result fields
    assign kind         = res.kind;
    assign column_index = res.column_index;
    assign out_char     = res.out_char;
    assign final_index  = res.final_index;
    assign last         = res.last;

endmodule

`default_nettype wire
